/* hw/rtl/okvt_pkg.sv */
// package: sizes, opcodes, state and cell control types of the ordered key/value table
package okvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OP_W        = 2;

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [OP_W-1:0]        op_t;

  // command codes; the fourth code is a no-op that answers like a miss
  localparam op_t OP_GET    = 2'd0;
  localparam op_t OP_PUT    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // per-cell control, driven by the top level
  typedef struct packed {
    logic valid;   // cell position is below the entry count
    logic append;  // cell takes the new key and value
    logic remove;  // remove with shift-down is in progress
    logic write;   // put overwrites the value of the matching cell
  } cell_ctl_t;

endpackage

/* hw/rtl/okvt_cell.sv */
// one entry cell: key/value storage, key compare, shift from upper neighbor
module okvt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmp_en,
  input  okvt_pkg::key_t        cmd_key,
  input  okvt_pkg::key_t        new_key,
  input  okvt_pkg::value_t      new_value,
  input  okvt_pkg::cell_ctl_t   ctl,
  input  okvt_pkg::key_t        nb_key,
  input  okvt_pkg::value_t      nb_value,
  input  logic                  after_in,
  input  okvt_pkg::value_t      sel_in,
  output okvt_pkg::key_t        cell_key,
  output okvt_pkg::value_t      cell_value,
  output logic                  match,
  output logic                  after_out,
  output okvt_pkg::value_t      sel_out
);

  logic after;

  // compare at the command transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmp_en) begin
      match <= ctl.valid && (cell_key == cmd_key);
    end
  end

  // match seen at or below this cell, and matched value gathered along the row
  assign after     = after_in | match;
  assign after_out = after;
  assign sel_out   = sel_in | (match ? cell_value : '0);

  // entry update: shift down, append or overwrite
  always_ff @(posedge clk) begin
    priority if (ctl.remove && after) begin
      cell_key   <= nb_key;
      cell_value <= nb_value;
    end else if (ctl.append) begin
      cell_key   <= new_key;
      cell_value <= new_value;
    end else if (ctl.write && match) begin
      cell_value <= new_value;
    end else begin
      cell_key   <= cell_key;
      cell_value <= cell_value;
    end
  end

endmodule

/* hw/rtl/ordered_key_value_table_core.sv */
// top level: insertion-ordered key/value table built as a row of entry cells
//
//  channel   signals                                      direction  transfer
//  command   start, opcode, key, value                    in         start && !busy
//  result    done, hit, prev_value, table_full,           out        done (one cycle)
//            entry_count
//
// for each command, all cells first compare the key as it is taken, then
// the apply state selects the matched value, shifts, appends or overwrites.
// busy is high during the apply cycle; the result strobe comes in the next
// cycle, when a new command can already be taken. synchronous reset empties
// the table (count zero); stored keys and values are not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
module ordered_key_value_table_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [okvt_pkg::OP_W-1:0]      opcode,
  input  logic [okvt_pkg::KEY_WIDTH-1:0] key,
  input  logic [okvt_pkg::VALUE_WIDTH-1:0] value,
  output logic                           busy,
  output logic                           done,
  output logic                           hit,
  output logic [okvt_pkg::VALUE_WIDTH-1:0] prev_value,
  output logic                           table_full,
  output logic [okvt_pkg::CNT_W-1:0]     entry_count
);

  localparam int DEPTH = okvt_pkg::TABLE_DEPTH;

  okvt_pkg::state_t state, state_next;
  okvt_pkg::cnt_t   count, count_next;
  okvt_pkg::op_t    op_r;
  okvt_pkg::key_t   key_r;
  okvt_pkg::value_t value_r;

  logic                 accept;
  logic                 apply;
  logic                 any_hit;
  logic                 op_hit;
  logic                 put_ok;
  logic                 do_append;
  logic                 is_full;
  okvt_pkg::value_t     hit_value;

  okvt_pkg::key_t       cell_keys   [DEPTH];
  okvt_pkg::value_t     cell_values [DEPTH];
  okvt_pkg::cell_ctl_t  ctls        [DEPTH];
  logic [DEPTH-1:0]     cell_hits;
  logic [DEPTH:0]       after_c;
  okvt_pkg::value_t     sel_c       [DEPTH+1];

  assign accept = start && !busy;
  assign apply  = (state == okvt_pkg::ST_APPLY);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      okvt_pkg::ST_IDLE:  if (accept) state_next = okvt_pkg::ST_APPLY;
      okvt_pkg::ST_APPLY: state_next = okvt_pkg::ST_IDLE;
      default:            state_next = okvt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state)
      okvt_pkg::ST_IDLE:  busy = 1'b0;
      okvt_pkg::ST_APPLY: busy = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okvt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode;
      key_r   <= key;
      value_r <= value;
    end
  end

  // decode of the apply cycle
  assign any_hit   = after_c[DEPTH];
  assign hit_value = sel_c[DEPTH];
  assign op_hit    = any_hit && (op_r != okvt_pkg::OP_NOP);
  assign put_ok    = (op_r == okvt_pkg::OP_PUT) && (key_r != '0);
  assign is_full   = (count == okvt_pkg::CNT_W'(DEPTH));
  assign do_append = apply && put_ok && !any_hit && !is_full;

  // entry count update
  always_comb begin
    count_next = count;
    priority if (apply && any_hit && (op_r == okvt_pkg::OP_REMOVE)) begin
      count_next = count - okvt_pkg::CNT_W'(1);
    end else if (do_append) begin
      count_next = count + okvt_pkg::CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      hit         <= op_hit;
      prev_value  <= op_hit ? hit_value : '0;
      table_full  <= put_ok && !any_hit && is_full;
      entry_count <= count_next;
    end
  end

  // row of cells; the top cell shifts in its own contents
  assign after_c[0] = 1'b0;
  assign sel_c[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    okvt_pkg::key_t   nb_key;
    okvt_pkg::value_t nb_value;

    if (i < DEPTH - 1) begin : g_nb
      assign nb_key   = cell_keys[i+1];
      assign nb_value = cell_values[i+1];
    end else begin : g_top
      assign nb_key   = cell_keys[i];
      assign nb_value = cell_values[i];
    end

    assign ctls[i].valid  = (okvt_pkg::CNT_W'(i) < count);
    assign ctls[i].append = do_append && (okvt_pkg::CNT_W'(i) == count);
    assign ctls[i].remove = apply && (op_r == okvt_pkg::OP_REMOVE);
    assign ctls[i].write  = apply && put_ok;

    okvt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmp_en     (accept),
      .cmd_key    (key),
      .new_key    (key_r),
      .new_value  (value_r),
      .ctl        (ctls[i]),
      .nb_key     (nb_key),
      .nb_value   (nb_value),
      .after_in   (after_c[i]),
      .sel_in     (sel_c[i]),
      .cell_key   (cell_keys[i]),
      .cell_value (cell_values[i]),
      .match      (cell_hits[i]),
      .after_out  (after_c[i+1]),
      .sel_out    (sel_c[i+1])
    );
  end

`ifndef ASSERT_OFF
  // stored keys are unique, so at most one cell matches
  a_match_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_hits))
    else $error("more than one cell matched");

  // a taken command always leads to a result strobe after the apply state
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("result strobe missing after command");

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= okvt_pkg::CNT_W'(DEPTH))
    else $error("entry count out of range");

  // a full drop is never also a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> !hit && entry_count == okvt_pkg::CNT_W'(DEPTH))
    else $error("inconsistent full result");

  // a miss reports a zero previous value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> prev_value == '0)
    else $error("nonzero previous value on miss");
`endif

endmodule
